### src/pso_pkg.sv
// Shared types, constants and saturation helpers of the particle swarm engine.
package pso_pkg;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_BOUNDS = 2'd1,
    OP_MOVE   = 2'd2,
    OP_SCORE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL,
    ST_SUM,
    ST_STEP,
    ST_ADD,
    ST_FIX,
    ST_CPRD,
    ST_CPWR
  } st_e;

  localparam logic [1:0] CFG_INERTIA = 2'd0;
  localparam logic [1:0] CFG_COG     = 2'd1;
  localparam logic [1:0] CFG_SOC     = 2'd2;
  localparam logic [1:0] CFG_STEP    = 2'd3;

  localparam logic [15:0] INERTIA_RST = 16'd22938;
  localparam logic [15:0] COG_RST     = 16'd384;
  localparam logic [15:0] SOC_RST     = 16'd640;
  localparam logic [15:0] STEP_RST    = 16'd256;

  localparam logic signed [31:0] MAX_S32    = 32'sh7fff_ffff;
  localparam logic signed [31:0] WHOLE_TOP  = 32'sh7fff_0000;
  localparam logic signed [47:0] HI48       = 48'sh0000_7fff_ffff;
  localparam logic signed [47:0] LO48       = 48'shffff_8000_0000;

  typedef struct packed {
    logic [1:0]         op;
    logic [6:0]         particle;
    logic [2:0]         dimension;
    logic signed [31:0] init_position;
    logic signed [31:0] init_velocity;
    logic signed [31:0] bound_low;
    logic signed [31:0] bound_high;
    logic               round_to_whole;
    logic signed [31:0] objective;
    logic [15:0]        rand_cog;
    logic [15:0]        rand_soc;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_out;
    logic signed [31:0] velocity_out;
    logic signed [31:0] personal_best_out;
    logic signed [31:0] global_best_out;
    logic signed [31:0] global_best_coord;
    logic               personal_improved;
    logic               global_improved;
    logic               was_clamped;
  } out_item_t;

  typedef struct packed {
    logic [15:0] inertia;
    logic [15:0] cog_gain;
    logic [15:0] soc_gain;
    logic [15:0] time_step;
  } cfg_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    op_e      op;
    logic     pok;
    logic     dok;
    in_item_t item;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x > HI48) begin
      r = MAX_S32;
    end else if (x < LO48) begin
      r = LO48[31:0];
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Round half away from zero to a whole Q16.16 value.
  function automatic logic signed [31:0] round_whole(input logic signed [31:0] x);
    logic [32:0] mag;
    logic [32:0] r;
    logic signed [31:0] res;
    if (!x[31]) begin
      mag = {1'b0, x} + 33'd32768;
      r   = {mag[32:16], 16'h0000};
      res = r[31] ? WHOLE_TOP : r[31:0];
    end else begin
      mag = (33'd0 - {x[31], x}) + 33'd32768;
      r   = {mag[32:16], 16'h0000};
      res = 32'(33'd0 - r);
    end
    return res;
  endfunction

endpackage

### src/pso_particle_update.sv
// Top level of the particle swarm update engine: configuration registers, front and back end.
// Particle swarm update engine in Q16.16. Items enter through a two-entry queue and one
// result per item leaves through a result register. After reset the best-value memory is
// cleared, one particle per cycle, before the first item is taken; configuration writes are
// taken at any time. In the back end init and bounds items finish in the dispatch state, move
// items pass the MUL, SUM, STEP, ADD and FIX states (a chain of registered multiplies and
// adds), and score items that copy a best vector repeat CPRD and CPWR per dimension through
// the single read port of the position stores. The back end holds one item at a time
// and starts the next once the previous result has been taken or the result register is empty.
module pso_particle_update #(
  parameter int PARTICLES  = 128,
  parameter int DIMENSIONS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  pso_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output pso_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  pso_pkg::cfg_t cfg_q;
  pso_pkg::cmd_t head;
  logic          avail, deq;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inertia   <= pso_pkg::INERTIA_RST;
      cfg_q.cog_gain  <= pso_pkg::COG_RST;
      cfg_q.soc_gain  <= pso_pkg::SOC_RST;
      cfg_q.time_step <= pso_pkg::STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pso_pkg::CFG_INERTIA: cfg_q.inertia   <= cfg_data_i;
        pso_pkg::CFG_COG:     cfg_q.cog_gain  <= cfg_data_i;
        pso_pkg::CFG_SOC:     cfg_q.soc_gain  <= cfg_data_i;
        pso_pkg::CFG_STEP:    cfg_q.time_step <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pso_front #(.PARTICLES(PARTICLES), .DIMENSIONS(DIMENSIONS)) u_front (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .item_i (in_item_i),
    .full_o (full),
    .deq_i  (deq),
    .avail_o(avail),
    .head_o (head)
  );

  pso_back #(.PARTICLES(PARTICLES), .DIMENSIONS(DIMENSIONS)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i  (cfg_q),
    .avail_i(avail),
    .head_i (head),
    .deq_o  (deq),
    .pop_i  (pop),
    .empty_o(empty),
    .res_o  (out_item_o)
  );

endmodule

### src/pso_ram.sv
// Generic single write port, single read port RAM with registered read.
module pso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/pso_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module pso_front #(
  parameter int PARTICLES  = 128,
  parameter int DIMENSIONS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pso_pkg::in_item_t item_i,
  output logic              full_o,
  input  logic              deq_i,
  output logic              avail_o,
  output pso_pkg::cmd_t     head_o
);

  pso_pkg::cmd_t ent_q [2];
  pso_pkg::cmd_t cmd_d;
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;
  logic          acc, deq;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign acc     = push_i && !full_o;
  assign deq     = deq_i && avail_o;
  assign head_o  = ent_q[rptr_q];

  always_comb begin
    cmd_d.op   = pso_pkg::op_e'(item_i.op);
    cmd_d.pok  = ({25'd0, item_i.particle} < 32'(PARTICLES));
    cmd_d.dok  = ({29'd0, item_i.dimension} < 32'(DIMENSIONS));
    cmd_d.item = item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (acc) begin
        wptr_q <= !wptr_q;
      end
      if (deq) begin
        rptr_q <= !rptr_q;
      end
      if (acc && !deq) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (deq && !acc) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ent_q[wptr_q] <= cmd_d;
    end
  end

endmodule

### src/pso_back.sv
// Back end: sequencer, particle stores and fixed-point datapath, with result register.
module pso_back #(
  parameter int PARTICLES  = 128,
  parameter int DIMENSIONS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pso_pkg::cfg_t      cfg_i,
  input  logic               avail_i,
  input  pso_pkg::cmd_t      head_i,
  output logic               deq_o,
  input  logic               pop_i,
  output logic               empty_o,
  output pso_pkg::out_item_t res_o
);

  localparam int CELLS = PARTICLES * DIMENSIONS;
  localparam int CW    = $clog2(CELLS);
  localparam int DW    = DIMENSIONS > 1 ? $clog2(DIMENSIONS) : 1;
  localparam int PW    = $clog2(PARTICLES);
  localparam logic [CW-1:0] DIM_C  = CW'(DIMENSIONS);
  localparam logic [DW-1:0] LAST_K = DW'(DIMENSIONS - 1);
  localparam logic [PW-1:0] LAST_P = PW'(PARTICLES - 1);

  pso_pkg::st_e       state_q, state_d;
  pso_pkg::cmd_t      cmd_q;
  pso_pkg::out_item_t res_q;
  logic               full_q, start, finish;
  logic [PW-1:0]      clr_q;
  logic signed [31:0] gbest_q;
  logic [DIMENSIONS-1:0] whole_q;
  logic [CW-1:0]      cell_q, base_q, head_cell, head_base;
  logic [DW-1:0]      dim_q, k_q, head_dim;
  logic [PW-1:0]      part_q, head_part;
  logic               pers_q, glob_q;

  // Datapath registers
  logic signed [34:0] wt_q;
  logic [31:0]        cc_q, sc_q;
  logic signed [31:0] dc_q, ds_q, nv_q, dx_q, nx_q;
  logic signed [40:0] ct_q, st_q;

  // RAM ports
  logic               pos_we, vel_we, bpos_we, gpos_we, lo_we, hi_we, bval_we;
  logic [CW-1:0]      pos_waddr, bpos_waddr, cell_raddr;
  logic [31:0]        pos_wdata, vel_wdata, cp_data, bval_wdata;
  logic [DW-1:0]      gpos_waddr;
  logic [PW-1:0]      bval_waddr;
  logic               cell_re;
  logic [31:0]        pos_rd, vel_rd, bpos_rd, gpos_rd, lo_rd, hi_rd, bval_rd;

  // Combinational datapath values
  logic signed [31:0] x, v, bv, obj, nb, fix_x, fix_v;
  logic               improve, gimprove, fix_c;
  logic signed [32:0] dcx, dsx, sx;
  logic signed [48:0] wprod, tprod;
  logic signed [64:0] cprod, sprod;
  logic signed [47:0] vsum;
  logic signed [31:0] nx_sat;

  assign head_part = PW'(head_i.item.particle);
  assign head_dim  = DW'(head_i.item.dimension);
  assign head_base = CW'(head_i.item.particle) * DIM_C;
  assign head_cell = head_base + CW'(head_i.item.dimension);

  assign start   = (state_q == pso_pkg::ST_IDLE) && avail_i && !full_q;
  assign deq_o   = start;
  assign finish  = (state_q != pso_pkg::ST_CLEAR) && (state_q != pso_pkg::ST_IDLE) &&
                   (state_d == pso_pkg::ST_IDLE);
  assign empty_o = !full_q;
  assign res_o   = res_q;

  assign cell_re    = start || (state_q == pso_pkg::ST_CPRD);
  assign cell_raddr = (state_q == pso_pkg::ST_CPRD) ? base_q + CW'(k_q) : head_cell;

  pso_ram #(.WIDTH(32), .DEPTH(CELLS)) u_pos (
    .clk_i, .we_i(pos_we), .waddr_i(pos_waddr), .wdata_i(pos_wdata),
    .re_i(cell_re), .raddr_i(cell_raddr), .rdata_o(pos_rd));
  pso_ram #(.WIDTH(32), .DEPTH(CELLS)) u_vel (
    .clk_i, .we_i(vel_we), .waddr_i(pos_waddr), .wdata_i(vel_wdata),
    .re_i(start), .raddr_i(head_cell), .rdata_o(vel_rd));
  pso_ram #(.WIDTH(32), .DEPTH(CELLS)) u_bpos (
    .clk_i, .we_i(bpos_we), .waddr_i(bpos_waddr), .wdata_i(cp_data),
    .re_i(cell_re), .raddr_i(cell_raddr), .rdata_o(bpos_rd));
  pso_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_gpos (
    .clk_i, .we_i(gpos_we), .waddr_i(gpos_waddr), .wdata_i(cp_data),
    .re_i(start), .raddr_i(head_dim), .rdata_o(gpos_rd));
  pso_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_lo (
    .clk_i, .we_i(lo_we), .waddr_i(dim_q), .wdata_i(cmd_q.item.bound_low),
    .re_i(start), .raddr_i(head_dim), .rdata_o(lo_rd));
  pso_ram #(.WIDTH(32), .DEPTH(DIMENSIONS)) u_hi (
    .clk_i, .we_i(hi_we), .waddr_i(dim_q), .wdata_i(cmd_q.item.bound_high),
    .re_i(start), .raddr_i(head_dim), .rdata_o(hi_rd));
  pso_ram #(.WIDTH(32), .DEPTH(PARTICLES)) u_bval (
    .clk_i, .we_i(bval_we), .waddr_i(bval_waddr), .wdata_i(bval_wdata),
    .re_i(start), .raddr_i(head_part), .rdata_o(bval_rd));

  assign x   = $signed(pos_rd);
  assign v   = $signed(vel_rd);
  assign bv  = $signed(bval_rd);
  assign obj = cmd_q.item.objective;

  assign improve  = obj < bv;
  assign nb       = improve ? obj : bv;
  assign gimprove = nb < gbest_q;
  assign cp_data  = pers_q ? pos_rd : bpos_rd;

  assign wprod = $signed(v) * $signed({1'b0, cfg_i.inertia});
  assign dcx   = $signed({bpos_rd[31], bpos_rd}) - $signed({x[31], x});
  assign dsx   = $signed({gpos_rd[31], gpos_rd}) - $signed({x[31], x});
  assign cprod = dc_q * $signed({1'b0, cc_q});
  assign sprod = ds_q * $signed({1'b0, sc_q});
  assign vsum  = 48'(wt_q) + 48'(ct_q) + 48'(st_q);
  assign tprod = nv_q * $signed({1'b0, cfg_i.time_step});
  assign sx    = $signed({x[31], x}) + $signed({dx_q[31], dx_q});
  assign nx_sat = pso_pkg::sat32(48'(sx));

  // Clamp; the lower bound is tested first
  always_comb begin
    fix_x = nx_q;
    fix_v = nv_q;
    fix_c = 1'b0;
    if (nx_q < $signed(lo_rd)) begin
      fix_x = $signed(lo_rd);
      fix_v = '0;
      fix_c = 1'b1;
    end else if (nx_q > $signed(hi_rd)) begin
      fix_x = $signed(hi_rd);
      fix_v = '0;
      fix_c = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    pos_we     = 1'b0;
    vel_we     = 1'b0;
    pos_waddr  = cell_q;
    pos_wdata  = fix_x;
    vel_wdata  = fix_v;
    bpos_we    = 1'b0;
    bpos_waddr = base_q + CW'(k_q);
    gpos_we    = 1'b0;
    gpos_waddr = k_q;
    lo_we      = 1'b0;
    hi_we      = 1'b0;
    bval_we    = 1'b0;
    bval_waddr = part_q;
    bval_wdata = obj;
    case (state_q)
      pso_pkg::ST_CLEAR: begin
        bval_we    = 1'b1;
        bval_waddr = clr_q;
        bval_wdata = pso_pkg::MAX_S32;
        if (clr_q == LAST_P) begin
          state_d = pso_pkg::ST_IDLE;
        end
      end
      pso_pkg::ST_IDLE: begin
        if (start) begin
          state_d = pso_pkg::ST_DISPATCH;
        end
      end
      pso_pkg::ST_DISPATCH: begin
        state_d = pso_pkg::ST_IDLE;
        case (cmd_q.op)
          pso_pkg::OP_INIT: begin
            pos_we    = cmd_q.pok && cmd_q.dok;
            vel_we    = cmd_q.pok && cmd_q.dok;
            pos_wdata = cmd_q.item.init_position;
            vel_wdata = cmd_q.item.init_velocity;
          end
          pso_pkg::OP_BOUNDS: begin
            lo_we = cmd_q.dok;
            hi_we = cmd_q.dok;
          end
          pso_pkg::OP_MOVE: begin
            if (cmd_q.pok && cmd_q.dok) begin
              state_d = pso_pkg::ST_MUL;
            end
          end
          pso_pkg::OP_SCORE: begin
            bval_we = cmd_q.pok && improve;
            if (cmd_q.pok && (improve || gimprove)) begin
              state_d = pso_pkg::ST_CPRD;
            end
          end
          default: state_d = pso_pkg::ST_IDLE;
        endcase
      end
      pso_pkg::ST_MUL:  state_d = pso_pkg::ST_SUM;
      pso_pkg::ST_SUM:  state_d = pso_pkg::ST_STEP;
      pso_pkg::ST_STEP: state_d = pso_pkg::ST_ADD;
      pso_pkg::ST_ADD:  state_d = pso_pkg::ST_FIX;
      pso_pkg::ST_FIX: begin
        pos_we  = 1'b1;
        vel_we  = 1'b1;
        state_d = pso_pkg::ST_IDLE;
      end
      pso_pkg::ST_CPRD: state_d = pso_pkg::ST_CPWR;
      pso_pkg::ST_CPWR: begin
        bpos_we = pers_q;
        gpos_we = glob_q;
        state_d = (k_q == LAST_K) ? pso_pkg::ST_IDLE : pso_pkg::ST_CPRD;
      end
      default: state_d = pso_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pso_pkg::ST_CLEAR;
      full_q  <= 1'b0;
      clr_q   <= '0;
      gbest_q <= pso_pkg::MAX_S32;
      whole_q <= '0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        full_q <= 1'b1;
      end else if (pop_i) begin
        full_q <= 1'b0;
      end
      if (state_q == pso_pkg::ST_CLEAR) begin
        clr_q <= clr_q + PW'(1);
      end
      if (state_q == pso_pkg::ST_DISPATCH) begin
        if (cmd_q.op == pso_pkg::OP_SCORE && cmd_q.pok && gimprove) begin
          gbest_q <= nb;
        end
        if (cmd_q.op == pso_pkg::OP_BOUNDS && cmd_q.dok) begin
          whole_q[dim_q] <= cmd_q.item.round_to_whole;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q  <= head_i;
      cell_q <= head_cell;
      base_q <= head_base;
      dim_q  <= head_dim;
      part_q <= head_part;
    end
    case (state_q)
      pso_pkg::ST_DISPATCH: begin
        res_q.position_out      <= (cmd_q.pok && cmd_q.dok) ? x : '0;
        res_q.velocity_out      <= (cmd_q.pok && cmd_q.dok) ? v : '0;
        res_q.personal_best_out <= cmd_q.pok ? bv : '0;
        res_q.global_best_out   <= gbest_q;
        res_q.global_best_coord <= cmd_q.dok ? $signed(gpos_rd) : '0;
        res_q.personal_improved <= 1'b0;
        res_q.global_improved   <= 1'b0;
        res_q.was_clamped       <= 1'b0;
        k_q    <= '0;
        pers_q <= cmd_q.pok && improve;
        glob_q <= cmd_q.pok && gimprove;
        wt_q   <= wprod[48:14];
        cc_q   <= cfg_i.cog_gain * cmd_q.item.rand_cog;
        sc_q   <= cfg_i.soc_gain * cmd_q.item.rand_soc;
        dc_q   <= pso_pkg::sat32(48'(dcx));
        ds_q   <= pso_pkg::sat32(48'(dsx));
        if (cmd_q.op == pso_pkg::OP_INIT) begin
          res_q.position_out <= (cmd_q.pok && cmd_q.dok) ? cmd_q.item.init_position : '0;
          res_q.velocity_out <= (cmd_q.pok && cmd_q.dok) ? cmd_q.item.init_velocity : '0;
        end
        if (cmd_q.op == pso_pkg::OP_SCORE && cmd_q.pok) begin
          res_q.personal_best_out <= nb;
          res_q.personal_improved <= improve;
          res_q.global_improved   <= gimprove;
          if (gimprove) begin
            res_q.global_best_out <= nb;
          end
        end
      end
      pso_pkg::ST_MUL: begin
        ct_q <= cprod[64:24];
        st_q <= sprod[64:24];
      end
      pso_pkg::ST_SUM:  nv_q <= pso_pkg::sat32(vsum);
      pso_pkg::ST_STEP: dx_q <= pso_pkg::sat32(48'($signed(tprod[48:8])));
      pso_pkg::ST_ADD:  nx_q <= whole_q[dim_q] ? pso_pkg::round_whole(nx_sat) : nx_sat;
      pso_pkg::ST_FIX: begin
        res_q.position_out <= fix_x;
        res_q.velocity_out <= fix_v;
        res_q.was_clamped  <= fix_c;
      end
      pso_pkg::ST_CPWR: begin
        // Catch the new global best coordinate as it streams past
        if (glob_q && cmd_q.dok && k_q == dim_q) begin
          res_q.global_best_coord <= $signed(cp_data);
        end
        k_q <= k_q + DW'(1);
      end
      default: ;
    endcase
  end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of the particle swarm update engine, driven through queue handshakes.
module tb_top;

  localparam int NPART = 128;
  localparam int NDIM  = 8;
  localparam int STALL_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  pso_pkg::in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  pso_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = pso_pkg::CFG_INERTIA;
  logic [15:0] cfg_data = '0;

  pso_particle_update uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .in_item_i(in_item),
    .empty(empty), .pop(pop), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Expected result, with flags telling which store-backed fields hold written data.
  typedef struct {
    pso_pkg::out_item_t val;
    bit                 cell_known;
    bit                 coord_known;
  } expected_t;

  pso_pkg::in_item_t pending_items[$];
  expected_t         expected_results[$];

  // Engine state as predicted.
  logic [15:0] w_inertia, w_cog, w_soc, w_dt;
  int pos[NPART*NDIM], vel[NPART*NDIM], bpos[NPART*NDIM];
  int gbpos[NDIM], lo_bound[NDIM], hi_bound[NDIM], best_val[NPART];
  int gbest_val;
  bit whole[NDIM], bound_known[NDIM], gb_known;
  bit cell_known[NPART*NDIM], best_row_known[NPART];

  int errors = 0, items_in = 0, results_out = 0, settings = 0;
  int in_gap = 0, out_gap = 0, idle_cycles = 0;
  bit quiet = 1'b0;

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint to_whole(longint x);
    longint r;
    if (x >= 0) begin
      r = ((x + 32768) >>> 16) <<< 16;
      if (r > 64'sd2147483647) r = 64'sh7fff0000;
    end else begin
      r = -(((-x + 32768) >>> 16) <<< 16);
    end
    return r;
  endfunction

  function automatic bit row_known(int p);
    for (int k = 0; k < NDIM; k++) if (!cell_known[p*NDIM+k]) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one item to the predicted state and queue the result it causes.
  function automatic void predict_update(pso_pkg::in_item_t it);
    int p, d, c, base;
    longint x, v, cc, sc, dc, ds, nv, nx;
    expected_t e;
    p = it.particle;
    d = it.dimension;
    c = p*NDIM + d;
    base = p*NDIM;
    e.val = '0;
    case (pso_pkg::op_e'(it.op))
      pso_pkg::OP_INIT: begin
        pos[c] = it.init_position;
        vel[c] = it.init_velocity;
        cell_known[c] = 1'b1;
      end
      pso_pkg::OP_BOUNDS: begin
        lo_bound[d] = it.bound_low;
        hi_bound[d] = it.bound_high;
        whole[d] = it.round_to_whole;
        bound_known[d] = 1'b1;
      end
      pso_pkg::OP_MOVE: begin
        x  = pos[c];
        v  = vel[c];
        cc = longint'(w_cog) * longint'(it.rand_cog);
        sc = longint'(w_soc) * longint'(it.rand_soc);
        dc = clip32(longint'(bpos[c]) - x);
        ds = clip32(longint'(gbpos[d]) - x);
        nv = clip32(((v * longint'(w_inertia)) >>> 14) + ((dc * cc) >>> 24)
                    + ((ds * sc) >>> 24));
        nx = clip32(x + clip32((nv * longint'(w_dt)) >>> 8));
        if (whole[d]) nx = to_whole(nx);
        if (nx < lo_bound[d]) begin
          nx = lo_bound[d];
          nv = 0;
          e.val.was_clamped = 1'b1;
        end else if (nx > hi_bound[d]) begin
          nx = hi_bound[d];
          nv = 0;
          e.val.was_clamped = 1'b1;
        end
        pos[c] = int'(nx);
        vel[c] = int'(nv);
      end
      pso_pkg::OP_SCORE: begin
        if (it.objective < best_val[p]) begin
          best_val[p] = it.objective;
          for (int k = 0; k < NDIM; k++) bpos[base+k] = pos[base+k];
          best_row_known[p] = 1'b1;
          e.val.personal_improved = 1'b1;
        end
        if (best_val[p] < gbest_val) begin
          gbest_val = best_val[p];
          for (int k = 0; k < NDIM; k++) gbpos[k] = bpos[base+k];
          gb_known = 1'b1;
          e.val.global_improved = 1'b1;
        end
      end
      default: ;
    endcase
    e.val.position_out      = pos[c];
    e.val.velocity_out      = vel[c];
    e.val.personal_best_out = best_val[p];
    e.val.global_best_out   = gbest_val;
    e.val.global_best_coord = gbpos[d];
    e.cell_known  = cell_known[c];
    e.coord_known = gb_known;
    expected_results.push_back(e);
  endfunction

  function automatic void queue_item(pso_pkg::in_item_t it);
    predict_update(it);
    pending_items.push_back(it);
  endfunction

  function automatic int rand_fix();
    if ($urandom_range(0, 3) == 0) return int'($urandom);
    return int'($urandom_range(0, 400*65536)) - 200*65536;
  endfunction

  function automatic pso_pkg::in_item_t noise_item();
    logic [223:0] raw;
    pso_pkg::in_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(pso_pkg::in_item_t)-1:0];
    return it;
  endfunction

  // Build one random item; steer it to a legal op when the chosen one would read unwritten data.
  function automatic pso_pkg::in_item_t random_item();
    pso_pkg::in_item_t it;
    int p, d, w, c;
    it = noise_item();
    p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NPART-1) : $urandom_range(0, 15);
    d = $urandom_range(0, NDIM-1);
    c = p*NDIM + d;
    it.particle = 7'(p);
    it.dimension = 3'(d);
    w = $urandom_range(0, 99);
    if (w < 25) it.op = pso_pkg::OP_INIT;
    else if (w < 35) it.op = pso_pkg::OP_BOUNDS;
    else if (w < 80) it.op = pso_pkg::OP_MOVE;
    else it.op = pso_pkg::OP_SCORE;
    if (it.op == pso_pkg::OP_MOVE) begin
      if (!cell_known[c]) it.op = pso_pkg::OP_INIT;
      else if (!bound_known[d]) it.op = pso_pkg::OP_BOUNDS;
      else if (!best_row_known[p] || !gb_known) it.op = pso_pkg::OP_SCORE;
    end
    if (it.op == pso_pkg::OP_SCORE && !row_known(p)) begin
      it.op = pso_pkg::OP_INIT;
      for (int k = NDIM-1; k >= 0; k--) if (!cell_known[p*NDIM+k]) it.dimension = 3'(k);
    end
    case (pso_pkg::op_e'(it.op))
      pso_pkg::OP_INIT: begin
        it.init_position = rand_fix();
        it.init_velocity = rand_fix() >>> $urandom_range(0, 8);
      end
      pso_pkg::OP_BOUNDS: begin
        it.bound_low  = rand_fix();
        it.bound_high = rand_fix();
        if ($urandom_range(0, 4) != 0 && it.bound_low > it.bound_high) begin
          it.bound_low  = it.bound_high;
          it.bound_high = int'(it.init_position);
        end
      end
      pso_pkg::OP_SCORE: begin
        case ($urandom_range(0, 3))
          0: it.objective = $urandom;
          1: it.objective = best_val[p];
          default: begin
            if (best_val[p] > -32'sd1000000000)
              it.objective = best_val[p] - int'($urandom_range(0, 5000));
          end
        endcase
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    errors++;
    $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, exp_v, got_v);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    case (idx)
      pso_pkg::CFG_INERTIA: w_inertia = val;
      pso_pkg::CFG_COG:     w_cog = val;
      pso_pkg::CFG_SOC:     w_soc = val;
      default:              w_dt = val;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Both sides: present the oldest pending item and assert pop, each with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_gap > 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_gap = $urandom_range(0, 18);
        push <= 1'b0;
      end else if (pending_items.size() != 0) begin
        push <= 1'b1;
        in_item <= pending_items[0];
      end else begin
        push <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(0, 18);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (push && !full) begin
      void'(pending_items.pop_front());
      items_in++;
    end
  end

  // Result side: check each item against the oldest expectation.
  always @(posedge clk_i) begin
    expected_t e;
    if (pop && !empty) begin
      results_out++;
      if (expected_results.size() == 0) begin
        report("unexpected item", '0, out_item.position_out);
      end else begin
        e = expected_results.pop_front();
        if (e.cell_known && out_item.position_out !== e.val.position_out)
          report("position_out", e.val.position_out, out_item.position_out);
        if (e.cell_known && out_item.velocity_out !== e.val.velocity_out)
          report("velocity_out", e.val.velocity_out, out_item.velocity_out);
        if (out_item.personal_best_out !== e.val.personal_best_out)
          report("personal_best_out", e.val.personal_best_out, out_item.personal_best_out);
        if (out_item.global_best_out !== e.val.global_best_out)
          report("global_best_out", e.val.global_best_out, out_item.global_best_out);
        if (e.coord_known && out_item.global_best_coord !== e.val.global_best_coord)
          report("global_best_coord", e.val.global_best_coord, out_item.global_best_coord);
        if (out_item.personal_improved !== e.val.personal_improved)
          report("personal_improved", 32'(e.val.personal_improved),
                 32'(out_item.personal_improved));
        if (out_item.global_improved !== e.val.global_improved)
          report("global_improved", 32'(e.val.global_improved),
                 32'(out_item.global_improved));
        if (out_item.was_clamped !== e.val.was_clamped)
          report("was_clamped", 32'(e.val.was_clamped), 32'(out_item.was_clamped));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    pso_pkg::in_item_t it;
    logic [15:0] vals [4];
    w_inertia = pso_pkg::INERTIA_RST;
    w_cog = pso_pkg::COG_RST;
    w_soc = pso_pkg::SOC_RST;
    w_dt = pso_pkg::STEP_RST;
    gbest_val = 32'sh7fffffff;
    for (int i = 0; i < NPART; i++) best_val[i] = 32'sh7fffffff;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under reset settings.
    for (int d = 0; d < NDIM; d++) begin
      it = noise_item();
      it.op = pso_pkg::OP_BOUNDS;
      it.dimension = 3'(d);
      it.bound_low = -(100 <<< 16);
      it.bound_high = 100 <<< 16;
      it.round_to_whole = 1'(d % 2);
      if (d == 2) begin
        // crossed bounds
        it.bound_low = 5 <<< 16;
        it.bound_high = -(5 <<< 16);
      end
      if (d == 3) begin
        it.bound_low = 32'sh80000000;
        it.bound_high = 32'sh7fffffff;
      end
      queue_item(it);
    end
    for (int d = 0; d < NDIM; d++) begin
      it = noise_item();
      it.op = pso_pkg::OP_INIT;
      it.particle = 7'd0;
      it.dimension = 3'(d);
      it.init_position = rand_fix() >>> 4;
      it.init_velocity = rand_fix() >>> 8;
      if (d == 0) it.init_velocity = 32'sh7fffffff;
      if (d == 1) it.init_position = 32'sh00008000;
      if (d == 3) begin
        it.init_position = 32'sh7fffffff;
        it.init_velocity = 32'sh80000000;
      end
      queue_item(it);
    end
    it = noise_item();
    it.op = pso_pkg::OP_SCORE;
    it.particle = 7'd0;
    it.objective = 32'sd1000;
    queue_item(it);
    // equal objective: no improvement
    queue_item(it);
    for (int d = 0; d < 4; d++) begin
      it = noise_item();
      it.op = pso_pkg::OP_MOVE;
      it.particle = 7'd0;
      it.dimension = 3'(d);
      it.rand_cog = (d == 0) ? 16'hffff : (d == 1) ? 16'h0000 : 16'($urandom);
      it.rand_soc = (d == 0) ? 16'h0000 : 16'hffff;
      queue_item(it);
    end
    it = noise_item();
    it.op = pso_pkg::OP_INIT;
    it.particle = 7'(NPART - 1);
    it.dimension = 3'(NDIM - 1);
    it.init_position = 32'sh80000000;
    it.init_velocity = 32'sh7fffffff;
    queue_item(it);

    // Random phases, each under its own register settings.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: vals = '{pso_pkg::INERTIA_RST, pso_pkg::COG_RST, pso_pkg::SOC_RST,
                    pso_pkg::STEP_RST};
        1: vals = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
        2: vals = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        3: vals = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        4: vals = '{16'($urandom_range(0, 32768)), 16'($urandom_range(0, 1024)),
                    16'($urandom_range(0, 1024)), 16'($urandom_range(0, 512))};
        default: vals = '{pso_pkg::INERTIA_RST, pso_pkg::COG_RST, pso_pkg::SOC_RST,
                          pso_pkg::STEP_RST};
      endcase
      if (ph != 0) begin
        write_reg(pso_pkg::CFG_INERTIA, vals[0]);
        write_reg(pso_pkg::CFG_COG, vals[1]);
        write_reg(pso_pkg::CFG_SOC, vals[2]);
        write_reg(pso_pkg::CFG_STEP, vals[3]);
        settings++;
      end
      quiet = (ph == 5);
      for (int n = 0; n < 180; n++) queue_item(random_item());
    end

    drain();
    $display("Run covered %0d items and %0d results over %0d register settings,",
             items_in, results_out, settings + 1);
    $display("with init, bounds, move and score items on a mix of small and full-range data.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
